/* src/b64sc_pkg.sv */
// Shared types, constants and character mapping functions for the Base64 stream codec.
package b64sc_pkg;

    localparam int PADDR_W     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register index codes (paddr[2])
    localparam logic REG_DIRECTION = 1'b0;

    // Direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_char;
    } out_item_t;

    // One flushed group: up to four result bytes, emitted in index order
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
        logic            bad;
    } grp_t;

    typedef struct packed {
        logic       pad;
        logic       bad;
        logic [5:0] val;
    } sext_t;

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic logic is_dropped(input logic [7:0] c);
        return (c == 8'h0D) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h20) ||
               (c == 8'h08) || (c == 8'h07) || (c == 8'h0C) || (c == 8'h0B);
    endfunction

    // Bit 7 is ignored; pad and invalid characters give a zero sextet
    function automatic sext_t sextet_of(input logic [7:0] c);
        sext_t      r;
        logic [6:0] v;
        v = c[6:0];
        r = '0;
        if (v >= 7'h41 && v <= 7'h5A) begin
            r.val = 6'(v - 7'h41);
        end else if (v >= 7'h61 && v <= 7'h7A) begin
            r.val = 6'(v - 7'h61 + 7'd26);
        end else if (v >= 7'h30 && v <= 7'h39) begin
            r.val = 6'(v - 7'h30 + 7'd52);
        end else if (v == 7'h2B) begin
            r.val = 6'd62;
        end else if (v == 7'h2F) begin
            r.val = 6'd63;
        end else if (v == 7'h3D) begin
            r.pad = 1'b1;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

/* src/b64sc_front.sv */
// Front end: accepts items, gathers groups and pushes finished groups to the queue.
module b64sc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                dir,
    input  logic                cfg_clear,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64sc_pkg::in_item_t s_data,
    output logic                q_push,
    output b64sc_pkg::grp_t     q_data,
    input  logic                q_ready
);

    logic [23:0] group_bits_reg, group_bits_next;
    logic [2:0]  group_count_reg, group_count_next;
    logic [1:0]  pad_count_reg, pad_count_next;
    logic        group_bad_reg, group_bad_next;

    b64sc_pkg::sext_t sx;
    logic             drop;
    logic             accept;

    logic [23:0] enc_bits, enc_al;
    logic [2:0]  enc_cnt;
    logic        enc_flush;
    b64sc_pkg::grp_t enc_grp;

    logic [23:0] dn_bits, src_bits, dec_al;
    logic [2:0]  dn_cnt, src_cnt, nonpad, nbytes;
    logic [1:0]  dn_pad, src_pad;
    logic        dn_bad, src_bad;
    logic        dec_flush;
    b64sc_pkg::grp_t dec_grp;

    logic flush;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        sx   = b64sc_pkg::sextet_of(s_data.in_byte);
        drop = b64sc_pkg::is_dropped(s_data.in_byte);

        // encode: left-align a short group so sextets sit at fixed places
        enc_bits = {group_bits_reg[15:0], s_data.in_byte};
        enc_cnt  = group_count_reg + 3'd1;
        unique case (enc_cnt)
            3'd1:    enc_al = enc_bits << 16;
            3'd2:    enc_al = enc_bits << 8;
            default: enc_al = enc_bits;
        endcase
        for (int k = 0; k < 4; k++) begin
            enc_grp.bytes[k] = (3'(k) <= enc_cnt) ?
                               b64sc_pkg::b64_char(enc_al[23-6*k -: 6]) :
                               b64sc_pkg::PAD_CHAR;
        end
        enc_grp.cnt  = 3'd4;
        enc_grp.last = s_data.in_last;
        enc_grp.bad  = 1'b0;
        enc_flush    = (enc_cnt >= 3'd3) || s_data.in_last;

        // decode: a dropped character carrying in_last flushes the state as it stands
        dn_bits = {group_bits_reg[17:0], sx.val};
        dn_cnt  = group_count_reg + 3'd1;
        dn_pad  = pad_count_reg + {1'b0, (sx.pad && pad_count_reg != 2'd3)};
        dn_bad  = group_bad_reg | sx.bad;
        if (drop) begin
            src_bits  = group_bits_reg;
            src_cnt   = group_count_reg;
            src_pad   = pad_count_reg;
            src_bad   = group_bad_reg;
            dec_flush = s_data.in_last && (group_count_reg != 3'd0);
        end else begin
            src_bits  = dn_bits;
            src_cnt   = dn_cnt;
            src_pad   = dn_pad;
            src_bad   = dn_bad;
            dec_flush = (dn_cnt == 3'd4) || s_data.in_last;
        end
        unique case (src_cnt)
            3'd1:    dec_al = src_bits << 18;
            3'd2:    dec_al = src_bits << 12;
            3'd3:    dec_al = src_bits << 6;
            default: dec_al = src_bits;
        endcase
        nonpad = ({1'b0, src_pad} < src_cnt) ? (src_cnt - {1'b0, src_pad}) : 3'd0;
        nbytes = (nonpad > 3'd1) ? (nonpad - 3'd1) : 3'd0;
        dec_grp.bytes[0] = dec_al[23:16];
        dec_grp.bytes[1] = dec_al[15:8];
        dec_grp.bytes[2] = dec_al[7:0];
        dec_grp.bytes[3] = 8'h00;
        dec_grp.cnt      = nbytes;
        dec_grp.last     = s_data.in_last;
        dec_grp.bad      = src_bad;

        if (dir == b64sc_pkg::DIR_DECODE) begin
            q_data = dec_grp;
            flush  = dec_flush;
        end else begin
            q_data = enc_grp;
            flush  = enc_flush;
        end
        // a decode group with no byte to give is dropped here
        q_push = accept && flush && (q_data.cnt != 3'd0);
    end

    always_comb begin
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        pad_count_next   = pad_count_reg;
        group_bad_next   = group_bad_reg;
        if (cfg_clear || (accept && flush)) begin
            group_bits_next  = '0;
            group_count_next = '0;
            pad_count_next   = '0;
            group_bad_next   = 1'b0;
        end else if (accept) begin
            if (dir == b64sc_pkg::DIR_ENCODE) begin
                group_bits_next  = enc_bits;
                group_count_next = enc_cnt;
            end else if (!drop) begin
                group_bits_next  = dn_bits;
                group_count_next = dn_cnt;
                pad_count_next   = dn_pad;
                group_bad_next   = dn_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            pad_count_reg   <= '0;
            group_bad_reg   <= 1'b0;
        end else begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            pad_count_reg   <= pad_count_next;
            group_bad_reg   <= group_bad_next;
        end
    end

endmodule

/* src/b64sc_queue.sv */
// Short group queue between the front and back ends.
module b64sc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  b64sc_pkg::grp_t push_data,
    output logic            push_ready,
    input  logic            pop,
    output b64sc_pkg::grp_t pop_data,
    output logic            pop_valid
);

    b64sc_pkg::grp_t mem [b64sc_pkg::QUEUE_DEPTH];

    logic [b64sc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [b64sc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [b64sc_pkg::QCNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != b64sc_pkg::QCNT_W'(b64sc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= b64sc_pkg::QCNT_W'(b64sc_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue empty with pointers apart");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow queue");
`endif

endmodule

/* src/b64sc_back.sv */
// Back end: pulls groups from the queue and hands out their result items one at a time.
module b64sc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    input  b64sc_pkg::grp_t      pop_data,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output b64sc_pkg::out_item_t m_data
);

    b64sc_pkg::grp_t cur_reg, cur_next;
    logic            cur_valid_reg, cur_valid_next;
    logic [1:0]      idx_reg, idx_next;

    logic fire;
    logic last_of;

    assign last_of = ({1'b0, idx_reg} == (cur_reg.cnt - 3'd1));
    assign fire    = cur_valid_reg && m_ready;
    assign pop     = pop_valid && (!cur_valid_reg || (fire && last_of));

    assign m_valid         = cur_valid_reg;
    assign m_data.out_byte = cur_reg.bytes[idx_reg];
    assign m_data.out_last = cur_reg.last && last_of;
    assign m_data.bad_char = cur_reg.bad;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_next       = pop_data;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (fire) begin
            if (last_of) begin
                cur_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> ({1'b0, idx_reg} < cur_reg.cnt))
        else $error("item index beyond group size");

    a_no_empty_group: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg.cnt != 3'd0))
        else $error("empty group held in back end");

    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (cur_valid_reg && idx_reg == 2'd0))
        else $error("popped group not loaded");
`endif

endmodule

/* src/base64_stream_codec.sv */
// Top level of the Base64 stream codec: config register, front end, queue, back end.
//
//  channel  direction  handshake        payload
//  s_       in         s_valid/s_ready  in_item_t  {in_byte, in_last}
//  m_       out        m_valid/m_ready  out_item_t {out_byte, out_last, bad_char}
//  apb      in         psel/penable     direction at paddr 0
//
// The front end takes one item per cycle while the queue is not full; the group that an
// item flushes is written to the queue, then loaded into the back end, which gives one
// result per cycle while m_ready is high. Encode yields four results for every three
// items, so the output side limits it; decode sustains one item per cycle.
// s_ready drops only while the four-group queue is full.
// Reset is synchronous and takes effect at the next clock edge; there is no clearing pass.
module base64_stream_codec (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [b64sc_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  b64sc_pkg::in_item_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output b64sc_pkg::out_item_t             m_data
);

    logic direction_reg, direction_next;
    logic cfg_clear;

    logic            q_push, q_ready, q_pop, q_valid;
    b64sc_pkg::grp_t q_in, q_out;

    assign pready    = 1'b1;
    assign cfg_clear = psel && penable && pwrite &&
                       (paddr[2] == b64sc_pkg::REG_DIRECTION);
    assign prdata    = (paddr[2] == b64sc_pkg::REG_DIRECTION) ?
                       {31'b0, direction_reg} : 32'b0;

    always_comb begin
        direction_next = direction_reg;
        if (cfg_clear) begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= b64sc_pkg::DIR_ENCODE;
        end else begin
            direction_reg <= direction_next;
        end
    end

    b64sc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dir       (direction_reg),
        .cfg_clear (cfg_clear),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_ready   (q_ready)
    );

    b64sc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out),
        .pop_valid  (q_valid)
    );

    b64sc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_valid),
        .pop_data  (q_out),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* dv/b64sc_tb_pkg.sv */
// Testbench package: stimulus constants and the scoreboard for the Base64 stream codec.
`timescale 1ns / 100ps

package b64sc_tb_pkg;

    import b64sc_pkg::*;

    localparam logic [7:0] WS_CHARS [8] = '{8'h0D, 8'h0A, 8'h09, 8'h20,
                                            8'h08, 8'h07, 8'h0C, 8'h0B};
    localparam int SEXTET_PAD = 64;
    localparam int SEXTET_BAD = 255;

    function automatic bit is_ws(logic [7:0] c);
        foreach (WS_CHARS[i]) begin
            if (c == WS_CHARS[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    class b64_scoreboard;
        string       alphabet =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        out_item_t   exp_q[$];
        logic [23:0] bits;
        int          cnt;
        int          pads;
        bit          bad;
        logic        dir;
        int          errors;

        function void clear_group();
            bits = '0;
            cnt  = 0;
            pads = 0;
            bad  = 1'b0;
        endfunction

        function void set_direction(logic d);
            dir = d;
            clear_group();
        endfunction

        function int sextet(logic [7:0] c);
            logic [6:0] v;
            v = c[6:0];
            if (v >= "A" && v <= "Z") return int'(v) - int'("A");
            if (v >= "a" && v <= "z") return int'(v) - int'("a") + 26;
            if (v >= "0" && v <= "9") return int'(v) - int'("0") + 52;
            if (v == "+") return 62;
            if (v == "/") return 63;
            if (v == "=") return SEXTET_PAD;
            return SEXTET_BAD;
        endfunction

        // left-justify the partial group, pad the unused character slots
        function void flush_enc(bit last);
            logic [23:0] b;
            logic [5:0]  s;
            out_item_t   o;
            b = bits << (8 * (3 - cnt));
            for (int k = 0; k < 4; k++) begin
                s = 6'(b >> (18 - 6 * k));
                o.out_byte = (k <= cnt) ? alphabet[s] : PAD_CHAR;
                o.out_last = last && (k == 3);
                o.bad_char = 1'b0;
                exp_q.push_back(o);
            end
            clear_group();
        endfunction

        function void flush_dec(bit last);
            logic [23:0] b;
            int          nonpad;
            int          nb;
            out_item_t   o;
            b = bits << (6 * (4 - cnt));
            nonpad = (pads < cnt) ? cnt - pads : 0;
            nb = (nonpad > 1) ? nonpad - 1 : 0;
            if (nb > 3) nb = 3;
            for (int k = 0; k < nb; k++) begin
                o.out_byte = 8'(b >> (16 - 8 * k));
                o.out_last = last && (k + 1 == nb);
                o.bad_char = bad;
                exp_q.push_back(o);
            end
            clear_group();
        endfunction

        function void note_input(in_item_t it);
            logic [7:0] c;
            bit         last;
            int         v;
            c    = it.in_byte;
            last = it.in_last;
            if (dir == DIR_ENCODE) begin
                bits = {bits[15:0], c};
                cnt++;
                if (cnt >= 3 || last) flush_enc(last);
                return;
            end
            if (!is_ws(c)) begin
                v = sextet(c);
                if (v == SEXTET_PAD) begin
                    v = 0;
                    if (pads < 3) pads++;
                end else if (v == SEXTET_BAD) begin
                    v = 0;
                    bad = 1'b1;
                end
                bits = {bits[17:0], 6'(v)};
                cnt++;
                if (cnt >= 4) begin
                    flush_dec(last);
                    return;
                end
            end
            // last on a dropped char still flushes a partial group
            if (last && cnt > 0) flush_dec(last);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (exp_q.size() == 0) begin
                $error("unexpected result item: out_byte %02h", got.out_byte);
                errors++;
                return;
            end
            want = exp_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h actual %02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.out_last !== want.out_last) begin
                $error("out_last: expected %0b actual %0b", want.out_last, got.out_last);
                errors++;
            end
            if (got.bad_char !== want.bad_char) begin
                $error("bad_char: expected %0b actual %0b", want.bad_char, got.bad_char);
                errors++;
            end
        endfunction

        function int pending();
            return exp_q.size();
        endfunction
    endclass

endpackage

/* dv/base64_stream_codec_tb.sv */
// Testbench top for the Base64 stream codec: drivers, monitor, directed and random stimulus.
`timescale 1ns / 100ps

module base64_stream_codec_tb;

    import b64sc_pkg::*;
    import b64sc_tb_pkg::*;

    localparam logic [PADDR_W-1:0] DIR_ADDR = PADDR_W'({REG_DIRECTION, 2'b00});
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 28;

    localparam in_item_t ENC_DIRECTED [7] = '{
        {8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h80, 1'b0},
        {8'h7F, 1'b1},
        {8'h55, 1'b0}, {8'hAA, 1'b1},
        {8'h12, 1'b0}   // left open, dropped by the next direction write
    };

    localparam in_item_t DEC_DIRECTED [22] = '{
        {"T", 1'b0}, {"W", 1'b0}, {"F", 1'b0}, {8'hF5, 1'b0},   // high-bit 'u'
        {8'h0A, 1'b0},
        {"T", 1'b0}, {"Q", 1'b0}, {8'hBD, 1'b0}, {"=", 1'b1},   // padded tail
        {"A", 1'b0}, {8'h8D, 1'b0}, {"/", 1'b0}, {"+", 1'b0},   // high-bit CR is invalid
        {"Z", 1'b0}, {"z", 1'b0}, {8'h20, 1'b1},                // last on whitespace
        {8'h09, 1'b1},                                          // last with nothing open
        {"=", 1'b0}, {"A", 1'b0}, {"B", 1'b0}, {"=", 1'b0},     // pads mid-group
        {"0", 1'b0}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;

    b64_scoreboard       sb = new;
    bit                  src_idle;
    bit                  sink_idle;
    int                  stall_cycles;
    logic [7:0]          msg_q[$];

    base64_stream_codec u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_input(s_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("base64_stream_codec_tb: done, errors");
            $finish;
        end
    end

    // result side: random stall bursts while enabled
    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (sink_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [7:0] b, bit last);
        in_item_t it;
        it.in_byte = b;
        it.in_last = last;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= DIR_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait for the block to drain, then switch direction and read it back
    task automatic set_direction(logic dir);
        logic [31:0] rd;
        s_valid <= 1'b0;
        // let the monitor note the last accepted item before waiting on the scoreboard
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        apb_xfer(1'b1, 32'(dir), rd);
        sb.set_direction(dir);
        @(posedge aclk);
        apb_xfer(1'b0, '0, rd);
        if (rd[0] !== dir) begin
            $error("direction: expected %0b actual %0b", dir, rd[0]);
            sb.errors++;
        end
        @(posedge aclk);
    endtask

    function automatic void add_char(logic [7:0] c);
        if ($urandom_range(0, 7) == 0) msg_q.push_back(WS_CHARS[$urandom_range(0, 7)]);
        if ($urandom_range(0, 7) == 0) c[7] = 1'b1;
        msg_q.push_back(c);
    endfunction

    task automatic send_enc_msg(inout int cnt);
        int len;
        bit closing;
        len = $urandom_range(1, 8);
        closing = $urandom_range(0, 7) != 0;
        for (int i = 0; i < len; i++) begin
            send_item(8'($urandom_range(0, 255)), closing && i == len - 1);
            cnt++;
        end
    endtask

    // mostly well-formed text with random content, some corrupted, some noise
    task automatic send_dec_msg(inout int cnt);
        int kind;
        int groups;
        int tail;
        bit closing;
        msg_q.delete();
        kind = $urandom_range(0, 9);
        closing = 1'b1;
        if (kind < 9) begin
            groups = $urandom_range(0, 2);
            tail = $urandom_range(0, 4);
            if (groups == 0 && tail == 0) tail = 1;
            repeat (groups * 4) add_char(sb.alphabet[$urandom_range(0, 63)]);
            repeat ((tail == 1 || tail == 3) ? 2 : (tail == 0 ? 0 : 3))
                add_char(sb.alphabet[$urandom_range(0, 63)]);
            if (tail == 1) begin
                add_char("=");
                add_char("=");
            end else if (tail == 2) begin
                add_char("=");
            end
            if ($urandom_range(0, 3) == 0) msg_q.push_back(WS_CHARS[$urandom_range(0, 7)]);
            if (kind >= 7) msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
            repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
            closing = $urandom_range(0, 1);
        end
        foreach (msg_q[i]) begin
            send_item(msg_q[i], closing && i == msg_q.size() - 1);
            if (!is_ws(msg_q[i])) cnt++;
        end
    endtask

    initial begin
        int   cnt;
        logic dir;
        aresetn   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        sb.set_direction(DIR_ENCODE);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_direction(DIR_ENCODE);
        foreach (ENC_DIRECTED[i]) send_item(ENC_DIRECTED[i].in_byte, ENC_DIRECTED[i].in_last);
        set_direction(DIR_DECODE);
        foreach (DEC_DIRECTED[i]) send_item(DEC_DIRECTED[i].in_byte, DEC_DIRECTED[i].in_last);

        for (int ph = 0; ph < PHASES; ph++) begin
            dir = (ph % 2 == 0) ? DIR_ENCODE : DIR_DECODE;
            set_direction(dir);
            cnt = 0;
            while (cnt < ITEMS_PER_PHASE) begin
                // final phase runs flat out on both sides
                src_idle  = (ph != PHASES - 1) && $urandom_range(0, 2) != 0;
                sink_idle = (ph != PHASES - 1) && $urandom_range(0, 2) != 0;
                if (dir == DIR_ENCODE) begin
                    send_enc_msg(cnt);
                end else begin
                    send_dec_msg(cnt);
                end
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("base64_stream_codec_tb: done, clean");
        end else begin
            $display("base64_stream_codec_tb: done, errors");
        end
        $finish;
    end

endmodule
